@@ sv/ssps_pkg.sv @@
`timescale 1ns / 1ps
package ssps_pkg;

  localparam int MaxVertices    = 4096;
  localparam int MaxWalls       = 2048;
  localparam int MaxSectors     = 256;
  localparam int MaxSectorWalls = 127;

  localparam int CoordW  = 31;
  localparam int NormW   = 18;
  localparam int VertW   = 32;
  localparam int IdxW    = 12;
  localparam int MarginW = 32;
  localparam int CountW  = 9;
  localparam int DotW    = 72;

  localparam logic [31:0] MarginReset = 32'd4294967;
  localparam logic [7:0]  SameSectorCode = 8'sd99;

  typedef enum logic [1:0] {
    REQ_VERTEX = 2'd0,
    REQ_WALL   = 2'd1,
    REQ_SECTOR = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef enum logic {
    CFG_MARGIN = 1'b0,
    CFG_COUNT  = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BND_A,
    ST_BND_B,
    ST_PLANE_RD,
    ST_PLANE_VX,
    ST_RANGE,
    ST_CORNER_RD,
    ST_CORNER_VX,
    ST_MUL,
    ST_SUM,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start_query;   // latch sectors, pass = 0
    logic rd_bounds_a;   // read bounds of plane sector
    logic rd_bounds_b;   // read bounds of clear sector
    logic rd_plane;      // read plane wall first corner and normal
    logic rd_plane_vx;   // read base vertex
    logic init_walk;     // w = first of clear sector, k = 0
    logic rd_corner;     // read wall corners of w
    logic rd_corner_vx;  // read vertex of corner k
    logic mul;
    logic sum;
    logic next_corner;
    logic next_plane;
    logic swap;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic same;
    logic plane_empty;   // plane sector has no walls
    logic clear_empty;   // clear sector has no walls
    logic over;          // dot above margin
    logic last_corner;   // k == 3 and w == last
    logic last_plane;    // plane wall is the last
    logic pass2;
  } stat_t;

endpackage

@@ sv/ssps_if.sv @@
`timescale 1ns / 1ps
interface ssps_in_if;
  import ssps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [IdxW-1:0]          entry_index;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  logic [IdxW-1:0]          corner_a;
  logic [IdxW-1:0]          corner_b;
  logic [IdxW-1:0]          corner_c;
  logic [IdxW-1:0]          corner_d;
  modport source (output valid, req_type, entry_index, coord_x, coord_y, coord_z,
                  corner_a, corner_b, corner_c, corner_d, input ready);
  modport sink (input valid, req_type, entry_index, coord_x, coord_y, coord_z,
                corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface ssps_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] cut_code;
  logic              no_separator;
  logic              bad_index;
  modport source (output valid, cut_code, no_separator, bad_index, input ready);
  modport sink (input valid, cut_code, no_separator, bad_index, output ready);
endinterface

interface ssps_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ssps_ctrl.sv @@
`timescale 1ns / 1ps
module ssps_ctrl
  import ssps_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  query,
  input  logic  out_free,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (query) state_next = ST_BND_A;
      ST_BND_A:     state_next = ST_BND_B;
      ST_BND_B: begin
        if (stat.bad || stat.same) state_next = ST_DONE;
        else state_next = ST_PLANE_RD;
      end
      ST_PLANE_RD: begin
        if (stat.plane_empty) state_next = stat.pass2 ? ST_DONE : ST_BND_A;
        else state_next = ST_PLANE_VX;
      end
      ST_PLANE_VX:  state_next = ST_RANGE;
      ST_RANGE:     state_next = stat.clear_empty ? ST_DONE : ST_CORNER_RD;
      ST_CORNER_RD: state_next = ST_CORNER_VX;
      ST_CORNER_VX: state_next = ST_MUL;
      ST_MUL:       state_next = ST_SUM;
      ST_SUM:       state_next = ST_CMP;
      ST_CMP: begin
        priority if (stat.over) begin
          if (!stat.last_plane) state_next = ST_PLANE_RD;
          else if (!stat.pass2) state_next = ST_BND_A;
          else state_next = ST_DONE;
        end else if (stat.last_corner) state_next = ST_DONE;
        else state_next = ST_CORNER_RD;
      end
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:      cmd.start_query = query;
      ST_BND_A:     cmd.rd_bounds_a = 1'b1;
      ST_BND_B:     cmd.rd_bounds_b = 1'b1;
      ST_PLANE_RD: begin
        cmd.rd_plane = 1'b1;
        cmd.swap     = stat.plane_empty && !stat.pass2;
      end
      ST_PLANE_VX:  cmd.rd_plane_vx = 1'b1;
      ST_RANGE:     cmd.init_walk = 1'b1;
      ST_CORNER_RD: cmd.rd_corner = 1'b1;
      ST_CORNER_VX: cmd.rd_corner_vx = 1'b1;
      ST_MUL:       cmd.mul = 1'b1;
      ST_SUM:       cmd.sum = 1'b1;
      ST_CMP: begin
        cmd.next_corner = !stat.over;
        cmd.next_plane  = stat.over;
        cmd.swap        = stat.over && stat.last_plane && !stat.pass2;
      end
      ST_DONE:      cmd.emit = out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

@@ sv/ssps_datapath.sv @@
`timescale 1ns / 1ps
module ssps_datapath
  import ssps_pkg::*;
#(
  parameter int MAX_VERTICES     = MaxVertices,
  parameter int MAX_WALLS        = MaxWalls,
  parameter int MAX_SECTORS      = MaxSectors,
  parameter int MAX_SECTOR_WALLS = MaxSectorWalls
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [1:0]               req_type,
  input  logic [IdxW-1:0]          entry_index,
  input  logic signed [CoordW-1:0] coord_x,
  input  logic signed [CoordW-1:0] coord_y,
  input  logic signed [CoordW-1:0] coord_z,
  input  logic [IdxW-1:0]          corner_a,
  input  logic [IdxW-1:0]          corner_b,
  input  logic [IdxW-1:0]          corner_c,
  input  logic [IdxW-1:0]          corner_d,
  input  logic [MarginW-1:0]       plane_margin,
  input  logic [CountW-1:0]        sector_count,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  output logic signed [7:0]        cut_code,
  output logic                     no_separator,
  output logic                     bad_index
);

  localparam int VaW = $clog2(MAX_VERTICES);
  localparam int WaW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int SaW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

  logic [VertW-1:0] vx_mem [MAX_VERTICES];
  logic [VertW-1:0] vy_mem [MAX_VERTICES];
  logic [VertW-1:0] vz_mem [MAX_VERTICES];
  logic [4*IdxW-1:0] wc_mem [MAX_WALLS];
  logic [3*NormW-1:0] wn_mem [MAX_WALLS];
  logic [2*IdxW-1:0] sb_mem [MAX_SECTORS];

  logic [IdxW-1:0] s1, s2, sc;
  logic            pass2;
  logic            bad, same;
  logic [IdxW-1:0] pf, pl, cf, cl, pw, cw;
  logic            p_empty, c_empty;
  logic [1:0]      k;
  logic [IdxW-1:0] pcorn;
  logic [4*IdxW-1:0] ccorn;
  logic signed [NormW-1:0] nx, ny, nz;
  logic signed [VertW-1:0] bx, by, bz;
  logic signed [VertW-1:0] vx, vy, vz;
  logic [VaW-1:0]  vaddr;
  logic            vvalid;
  logic [VertW-1:0] rx, ry, rz;
  logic signed [VertW:0] dx, dy, dz;
  logic signed [VertW+NormW:0] mx, my, mz;
  logic signed [DotW-1:0] px, py, pz, dot;
  logic signed [7:0] code;
  logic nosep;
  logic [2*IdxW-1:0] bnd;
  logic [SaW-1:0]  baddr;
  logic [IdxW-1:0] bf, bl, blim;
  logic            b_empty;

  // writes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (req_t'(req_type))
        REQ_VERTEX: if ({1'b0, entry_index} < (IdxW+1)'(MAX_VERTICES)) begin
          vx_mem[entry_index[VaW-1:0]] <= VertW'(coord_x);
          vy_mem[entry_index[VaW-1:0]] <= VertW'(coord_y);
          vz_mem[entry_index[VaW-1:0]] <= VertW'(coord_z);
        end
        REQ_WALL: if ({1'b0, entry_index} < (IdxW+1)'(MAX_WALLS)) begin
          wc_mem[entry_index[WaW-1:0]] <= {corner_d, corner_c, corner_b, corner_a};
          wn_mem[entry_index[WaW-1:0]] <= {coord_z[NormW-1:0], coord_y[NormW-1:0],
                                           coord_x[NormW-1:0]};
        end
        REQ_SECTOR: if ({1'b0, entry_index} < (IdxW+1)'(MAX_SECTORS)) begin
          sb_mem[entry_index[SaW-1:0]] <= {corner_b, corner_a};
        end
        default: ;
      endcase
    end
  end

  // bounds reads (shared port), decode effective range
  always_comb begin
    priority if (cmd.start_query) baddr = entry_index[SaW-1:0];
    else if (cmd.swap) baddr = s2[SaW-1:0];
    else baddr = sc[SaW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query || cmd.rd_bounds_a || cmd.swap)
      bnd <= sb_mem[baddr];
  end

  always_comb begin
    bl = bnd[2*IdxW-1:IdxW];
    bf = bnd[IdxW-1:0];
    b_empty = (bl < bf) || ({1'b0, bf} >= (IdxW+1)'(MAX_WALLS));
    blim = bl;
    if (bl - bf >= IdxW'(MAX_SECTOR_WALLS)) blim = bf + IdxW'(MAX_SECTOR_WALLS - 1);
    if ({1'b0, blim} >= (IdxW+1)'(MAX_WALLS)) blim = IdxW'(MAX_WALLS - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      s1 <= entry_index; s2 <= corner_a;
      sc <= corner_a;
      pass2 <= 1'b0;
      bad <= ({1'b0, entry_index} >= {4'b0, sector_count}) ||
             ({1'b0, corner_a} >= {4'b0, sector_count}) ||
             ({1'b0, entry_index} >= (IdxW+1)'(MAX_SECTORS)) ||
             ({1'b0, corner_a} >= (IdxW+1)'(MAX_SECTORS));
      same <= (entry_index == corner_a);
    end
    if (cmd.rd_bounds_a) begin
      pf <= bf; pl <= blim; p_empty <= b_empty; pw <= bf;
    end
    if (cmd.rd_bounds_b) begin
      cf <= bf; cl <= blim; c_empty <= b_empty;
    end
    if (cmd.swap) begin
      pass2 <= 1'b1; sc <= s1;
    end
    if (cmd.rd_plane) begin
      pcorn <= wc_mem[pw[WaW-1:0]][IdxW-1:0];
      {nz, ny, nx} <= wn_mem[pw[WaW-1:0]];
    end
    if (cmd.init_walk) begin cw <= cf; k <= 2'd0; end
    if (cmd.rd_corner) ccorn <= wc_mem[cw[WaW-1:0]];
    if (cmd.next_corner) begin
      k <= k + 2'd1;
      if (k == 2'd3) cw <= cw + 1'b1;
    end
    if (cmd.next_plane) pw <= pw + 1'b1;
  end

  // vertex read port
  logic [IdxW-1:0] vidx;
  always_comb begin
    unique case (k)
      2'd0: vidx = ccorn[IdxW-1:0];
      2'd1: vidx = ccorn[2*IdxW-1:IdxW];
      2'd2: vidx = ccorn[3*IdxW-1:2*IdxW];
      default: vidx = ccorn[4*IdxW-1:3*IdxW];
    endcase
    if (cmd.rd_plane_vx) vidx = pcorn;
    vaddr = vidx[VaW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_plane_vx || cmd.rd_corner_vx) begin
      rx <= vx_mem[vaddr]; ry <= vy_mem[vaddr]; rz <= vz_mem[vaddr];
      vvalid <= ({1'b0, vidx} < (IdxW+1)'(MAX_VERTICES));
    end
  end

  always_comb begin
    vx = vvalid ? rx : '0;
    vy = vvalid ? ry : '0;
    vz = vvalid ? rz : '0;
  end

  // 33 x 18 signed products
  always_comb begin
    dx = (VertW+1)'(vx) - (VertW+1)'(bx);
    dy = (VertW+1)'(vy) - (VertW+1)'(by);
    dz = (VertW+1)'(vz) - (VertW+1)'(bz);
    mx = dx * nx;
    my = dy * ny;
    mz = dz * nz;
  end

  always_ff @(posedge clk) begin
    if (cmd.init_walk) begin bx <= vx; by <= vy; bz <= vz; end
    if (cmd.mul) begin
      px <= DotW'(mx);
      py <= DotW'(my);
      pz <= DotW'(mz);
    end
    if (cmd.sum) dot <= px + py + pz;
  end

  always_comb begin
    stat.bad = bad;
    stat.same = same;
    stat.plane_empty = p_empty;
    stat.clear_empty = c_empty;
    stat.over = dot > $signed({{(DotW-MarginW){1'b0}}, plane_margin});
    stat.last_corner = (k == 2'd3) && (cw == cl);
    stat.last_plane = (pw == pl);
    stat.pass2 = pass2;
  end

  always_comb begin
    priority if (bad) begin code = '0; nosep = 1'b0; end
    else if (same) begin code = SameSectorCode; nosep = 1'b0; end
    else if ((!stat.over || c_empty) && !p_empty) begin
      code = 8'(pw - pf + 1'b1);
      if (pass2) code = -code;
      nosep = 1'b0;
    end else begin code = 8'sd1; nosep = 1'b1; end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cut_code <= code; no_separator <= nosep; bad_index <= bad;
    end
  end

endmodule

@@ sv/sector_separating_plane_search.sv @@
`timescale 1ns / 1ps
// channel | dir | beat
// in      | in  | req_type, entry_index, coord_x/y/z, corner_a..d
// out     | out | cut_code, no_separator, bad_index (queries only)
// cfg     | in  | index (0 margin, 1 sector count), data
// A query reads the bounds of both sectors on each pass, then for each plane
// wall tried reads the wall and its base vertex, and tests the corners of the
// other sector (four per wall) one at a time through the single vertex read
// port by multiply, sum and compare steps, and at the end emits its result.
// rst is synchronous; stores hold no reset. A result waits in its output
// register while the next query runs; a query done before it is taken stalls.
module sector_separating_plane_search
  import ssps_pkg::*;
#(
  parameter int MAX_VERTICES     = MaxVertices,
  parameter int MAX_WALLS        = MaxWalls,
  parameter int MAX_SECTORS      = MaxSectors,
  parameter int MAX_SECTOR_WALLS = MaxSectorWalls
) (
  input logic       clk,
  input logic       rst,
  ssps_in_if.sink   in_ch,
  ssps_out_if.source out_ch,
  ssps_cfg_if.sink  cfg
);

  logic [MarginW-1:0] plane_margin;
  logic [CountW-1:0]  sector_count;
  logic  busy, out_free, in_beat, query, out_valid;
  cmd_t  cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_margin <= MarginReset;
      sector_count <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_MARGIN: plane_margin <= cfg.data;
        CFG_COUNT:  sector_count <= cfg.data[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !busy;
  assign in_beat  = in_ch.valid && in_ch.ready;
  assign query    = in_beat && (in_ch.req_type == REQ_QUERY);
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end
  assign out_ch.valid = out_valid;

  ssps_ctrl u_ctrl (
    .clk, .rst, .query, .out_free, .stat, .busy, .cmd
  );

  ssps_datapath #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_WALLS(MAX_WALLS),
    .MAX_SECTORS(MAX_SECTORS), .MAX_SECTOR_WALLS(MAX_SECTOR_WALLS)
  ) u_dp (
    .clk,
    .wr_en(in_beat),
    .req_type(in_ch.req_type), .entry_index(in_ch.entry_index),
    .coord_x(in_ch.coord_x), .coord_y(in_ch.coord_y), .coord_z(in_ch.coord_z),
    .corner_a(in_ch.corner_a), .corner_b(in_ch.corner_b),
    .corner_c(in_ch.corner_c), .corner_d(in_ch.corner_d),
    .plane_margin, .sector_count, .cmd, .stat,
    .cut_code(out_ch.cut_code), .no_separator(out_ch.no_separator),
    .bad_index(out_ch.bad_index)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ssps_pkg::*;

  typedef struct {
    logic signed [7:0] code;
    logic              nosep;
    logic              bad;
  } cut_t;

  localparam int WatchLimit = 200000;
  localparam int NumVert = 32;
  localparam int NumWall = 132;
  localparam int NumSec = 32;
  localparam logic signed [30:0] CoordMax = 31'sd1073709056;
  localparam logic signed [30:0] CoordMin = -31'sd1073741824;

  logic clk;
  logic rst;

  ssps_in_if  in_ch();
  ssps_out_if out_ch();
  ssps_cfg_if cfg();

  sector_separating_plane_search dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  logic signed [31:0] vx_m [MaxVertices];
  logic signed [31:0] vy_m [MaxVertices];
  logic signed [31:0] vz_m [MaxVertices];
  logic [11:0]        wall_cn [MaxWalls][4];
  logic signed [17:0] wall_nm [MaxWalls][3];
  logic [11:0]        sec_lo [MaxSectors];
  logic [11:0]        sec_hi [MaxSectors];
  logic [31:0]        margin_r;
  logic [8:0]         count_r;

  cut_t cuts_due[$];
  int   errors;
  bit   idle_gaps;
  bit   long_hold;
  int   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_VERTEX;
    in_ch.entry_index <= '0;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    in_ch.coord_z <= '0;
    in_ch.corner_a <= '0;
    in_ch.corner_b <= '0;
    in_ch.corner_c <= '0;
    in_ch.corner_d <= '0;
    out_ch.ready <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_MARGIN;
    cfg.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("[sector_separating_plane_search] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit wall_span(int s, output int f, output int l);
    f = sec_lo[s];
    l = sec_hi[s];
    if (l < f || f >= MaxWalls) return 1'b0;
    if (l - f >= MaxSectorWalls) l = f + MaxSectorWalls - 1;
    if (l >= MaxWalls) l = MaxWalls - 1;
    return 1'b1;
  endfunction

  function automatic bit plane_clears(int pw, int s);
    int f, l, b, c;
    longint dot;
    b = wall_cn[pw][0];
    if (!wall_span(s, f, l)) return 1'b1;
    for (int w = f; w <= l; w++) begin
      for (int k = 0; k < 4; k++) begin
        c = wall_cn[w][k];
        dot = (longint'(vx_m[c]) - longint'(vx_m[b])) * longint'(wall_nm[pw][0])
            + (longint'(vy_m[c]) - longint'(vy_m[b])) * longint'(wall_nm[pw][1])
            + (longint'(vz_m[c]) - longint'(vz_m[b])) * longint'(wall_nm[pw][2]);
        if (dot > longint'(margin_r)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int first_plane(int a, int b);
    int f, l;
    if (!wall_span(a, f, l)) return 0;
    for (int w = f; w <= l; w++)
      if (plane_clears(w, b)) return w - f + 1;
    return 0;
  endfunction

  function automatic cut_t pair_cut(int s1, int s2);
    cut_t r;
    int p;
    r.code = 8'sd0;
    r.nosep = 1'b0;
    r.bad = 1'b0;
    if (s1 >= count_r || s2 >= count_r || s1 >= MaxSectors || s2 >= MaxSectors) begin
      r.bad = 1'b1;
    end else if (s1 == s2) begin
      r.code = SameSectorCode;
    end else begin
      p = first_plane(s1, s2);
      if (p != 0) begin
        r.code = p[7:0];
      end else begin
        p = first_plane(s2, s1);
        if (p != 0) begin
          r.code = -p[7:0];
        end else begin
          r.code = 8'sd1;
          r.nosep = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_beat(req_t t, int idx, logic signed [30:0] x, logic signed [30:0] y,
                           logic signed [30:0] z, int a, int b, int c, int d);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= t;
    in_ch.entry_index <= idx[11:0];
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    in_ch.corner_a <= a[11:0];
    in_ch.corner_b <= b[11:0];
    in_ch.corner_c <= c[11:0];
    in_ch.corner_d <= d[11:0];
    do @(posedge clk); while (!in_ch.ready);
    case (t)
      REQ_VERTEX: begin
        vx_m[idx] = 32'(x);
        vy_m[idx] = 32'(y);
        vz_m[idx] = 32'(z);
      end
      REQ_WALL: begin
        if (idx < MaxWalls) begin
          wall_cn[idx][0] = a[11:0];
          wall_cn[idx][1] = b[11:0];
          wall_cn[idx][2] = c[11:0];
          wall_cn[idx][3] = d[11:0];
          wall_nm[idx][0] = x[17:0];
          wall_nm[idx][1] = y[17:0];
          wall_nm[idx][2] = z[17:0];
        end
      end
      REQ_SECTOR: begin
        if (idx < MaxSectors) begin
          sec_lo[idx] = a[11:0];
          sec_hi[idx] = b[11:0];
        end
      end
      default: cuts_due.push_back(pair_cut(idx, a));
    endcase
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (cuts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t i, logic [31:0] v);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= i;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (i == CFG_MARGIN) margin_r = v;
    else count_r = v[8:0];
  endtask

  initial begin
    cut_t e;
    int g;
    forever begin
      @(posedge clk);
      if (!rst) break;
    end
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      g = idle_gaps ? $urandom_range(0, 18) : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (cuts_due.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = cuts_due.pop_front();
        if (out_ch.cut_code !== e.code) begin
          $error("cut_code exp %0d got %0d", e.code, out_ch.cut_code);
          errors++;
        end
        if (out_ch.no_separator !== e.nosep) begin
          $error("no_separator exp %0d got %0d", e.nosep, out_ch.no_separator);
          errors++;
        end
        if (out_ch.bad_index !== e.bad) begin
          $error("bad_index exp %0d got %0d", e.bad, out_ch.bad_index);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [30:0] rnd_coord(bit full);
    logic signed [30:0] v;
    if (full) begin
      v = 31'($urandom);
      if (v > CoordMax) v = CoordMax;
    end else begin
      v = 31'($urandom_range(0, 8192)) - 31'sd4096;
    end
    return v;
  endfunction

  function automatic logic signed [30:0] rnd_normal();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 4095)) <<< 18;
      1: return 31'($urandom_range(0, 8191)) - 31'sd4096;
      2: return rnd_coord(1'b1);
      default: return 31'($urandom_range(0, 65536)) - 31'sd32768;
    endcase
  endfunction

  // corners only name loaded vertices
  function automatic int rnd_vidx();
    if ($urandom_range(0, 15) == 0) return MaxVertices - 1;
    return $urandom_range(0, NumVert - 1);
  endfunction

  task automatic rnd_sector(int idx);
    int f;
    f = $urandom_range(0, NumWall - 4);
    case ($urandom_range(0, 9))
      0: send_beat(REQ_SECTOR, idx, 0, 0, 0, f + 1, f, 0, 0);
      1: send_beat(REQ_SECTOR, idx, 0, 0, 0, $urandom_range(MaxWalls, 4095), 4095, 0, 0);
      default: send_beat(REQ_SECTOR, idx, 0, 0, 0, f, f + $urandom_range(0, 3), 0, 0);
    endcase
  endtask

  task automatic rnd_wall(int idx);
    send_beat(REQ_WALL, idx, rnd_normal(), rnd_normal(), rnd_normal(),
              rnd_vidx(), rnd_vidx(), rnd_vidx(), rnd_vidx());
  endtask

  task automatic test_load_tables();
    idle_gaps = 1'b0;
    write_reg(CFG_COUNT, 9'd256);
    for (int i = 0; i < NumVert; i++)
      send_beat(REQ_VERTEX, i, rnd_coord(1'b0), rnd_coord(1'b0), rnd_coord(1'b0), 0, 0, 0, 0);
    send_beat(REQ_VERTEX, MaxVertices - 1, rnd_coord(1'b0), rnd_coord(1'b0),
              rnd_coord(1'b0), 0, 0, 0, 0);
    for (int i = 0; i < NumWall; i++) rnd_wall(i);
    for (int i = MaxWalls - 8; i < MaxWalls; i++) rnd_wall(i);
    for (int i = 0; i < NumSec; i++) rnd_sector(i);
  endtask

  task automatic test_directed();
    idle_gaps = 1'b1;
    write_reg(CFG_MARGIN, 32'd0);
    send_beat(REQ_VERTEX, 4095, CoordMin, CoordMax, -31'sd1, 0, 0, 0, 0);
    send_beat(REQ_VERTEX, 0, CoordMax, CoordMin, 31'sd0, 0, 0, 0, 0);
    send_beat(REQ_WALL, 2047, 31'h7FFFFFFF & CoordMax, 31'h0003FFFF, CoordMin,
              4095, 0, 4095, 0);
    send_beat(REQ_WALL, 4095, 0, 0, 0, 1, 2, 3, 4);
    send_beat(REQ_WALL, 10, 0, 0, 0, 0, 0, 0, 0);
    send_beat(REQ_SECTOR, 4095, 0, 0, 0, 0, 0, 0, 0);
    send_beat(REQ_SECTOR, 255, 0, 0, 0, 2040, 4095, 0, 0);
    send_beat(REQ_SECTOR, 1, 0, 0, 0, 0, 300, 0, 0);
    send_beat(REQ_SECTOR, 2, 0, 0, 0, 10, 10, 0, 0);
    send_beat(REQ_SECTOR, 3, 0, 0, 0, 9, 8, 0, 0);
    send_beat(REQ_SECTOR, 4, 0, 0, 0, 2048, 2050, 0, 0);
    send_beat(REQ_QUERY, 1, 0, 0, 0, 2, 0, 0, 0);
    send_beat(REQ_QUERY, 2, 0, 0, 0, 1, 0, 0, 0);
    send_beat(REQ_QUERY, 3, 0, 0, 0, 2, 0, 0, 0);
    send_beat(REQ_QUERY, 4, 0, 0, 0, 255, 0, 0, 0);
    send_beat(REQ_QUERY, 255, 0, 0, 0, 2, 0, 0, 0);
    send_beat(REQ_QUERY, 5, 0, 0, 0, 5, 0, 0, 0);
    send_beat(REQ_QUERY, 4095, 0, 0, 0, 4095, 0, 0, 0);
    send_beat(REQ_QUERY, 6, 0, 0, 0, 7, 0, 0, 0);
    write_reg(CFG_COUNT, 9'd5);
    send_beat(REQ_QUERY, 5, 0, 0, 0, 2, 0, 0, 0);
    send_beat(REQ_QUERY, 2, 0, 0, 0, 4, 0, 0, 0);
    write_reg(CFG_MARGIN, 32'hFFFFFFFF);
    send_beat(REQ_QUERY, 2, 0, 0, 0, 3, 0, 0, 0);
    write_reg(CFG_COUNT, 9'd0);
    send_beat(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random();
    int s1, s2, lim;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(CFG_MARGIN, MarginReset);
        1: write_reg(CFG_MARGIN, 32'hFFFFFFFF);
        2: write_reg(CFG_MARGIN, 32'd0);
        default: write_reg(CFG_MARGIN, $urandom);
      endcase
      case (ph)
        1: write_reg(CFG_COUNT, 9'd1);
        3: write_reg(CFG_COUNT, 9'($urandom_range(2, 256)));
        default: write_reg(CFG_COUNT, 9'd256);
      endcase
      idle_gaps = (ph != 2);
      lim = (count_r == 0) ? 1 : ((count_r > NumSec) ? NumSec : count_r);
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 9))
          0: send_beat(REQ_VERTEX, $urandom_range(0, 4095), rnd_coord($urandom_range(0, 3) == 0),
                       rnd_coord($urandom_range(0, 3) == 0),
                       rnd_coord($urandom_range(0, 3) == 0), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
          1: rnd_wall($urandom_range(0, 4095));
          2: rnd_sector($urandom_range(0, 4095) & ($urandom_range(0, 1) ? 12'hFFF : 12'h0FF));
          default: begin
            s1 = $urandom_range(0, lim - 1);
            s2 = $urandom_range(0, lim - 1);
            if ($urandom_range(0, 9) == 0) s2 = s1;
            if ($urandom_range(0, 9) == 0) s1 = $urandom_range(count_r, 4095);
            if ($urandom_range(0, 9) == 0) s2 = $urandom_range(count_r, 4095);
            if (s1 == 1 && s2 == 255 || s1 == 255 && s2 == 1) s2 = 2;
            send_beat(REQ_QUERY, s1, 0, 0, 0, s2, 0, 0, 0);
          end
        endcase
      end
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_COUNT, 9'd256);
    idle_gaps = 1'b0;
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++)
      send_beat(REQ_QUERY, $urandom_range(0, NumSec - 1), 0, 0, 0,
                $urandom_range(0, NumSec - 1), 0, 0, 0);
    in_ch.valid <= 1'b0;
    while (cuts_due.size() != 0) @(posedge clk);
    idle_gaps = 1'b1;
    for (int i = 0; i < 10; i++)
      send_beat(REQ_QUERY, $urandom_range(0, NumSec - 1), 0, 0, 0,
                $urandom_range(0, NumSec - 1), 0, 0, 0);
  endtask

  initial begin
    errors = 0;
    idle_gaps = 1'b0;
    long_hold = 1'b0;
    margin_r = MarginReset;
    count_r = '0;
    forever begin
      @(posedge clk);
      if (!rst) break;
    end
    test_load_tables();
    test_directed();
    test_random();
    test_backpressure();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && cuts_due.size() == 0) begin
      $display("[sector_separating_plane_search] OK");
    end else begin
      $display("[sector_separating_plane_search] ERROR");
    end
    $finish;
  end

endmodule
